FILE: rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared widths and default sizes for the LFU page replacement block.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int PAGE_W          = 16;
    localparam int SLOT_W          = 2;
    localparam int USE_W           = 16;
    localparam int STAMP_W         = 32;
    localparam int TOTAL_W         = 32;

    localparam int FRAME_COUNT_DEF = 4;
    localparam int PAGE_BITS_DEF   = 16;

endpackage

FILE: rtl/lfu_req_if.sv
// ----------------------------------------------------------------------------
// lfu_req_if
// Request channel carrying one page reference per request.
// ----------------------------------------------------------------------------
interface lfu_req_if
    import lfu_pkg::*;
();

    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);

endinterface

FILE: rtl/lfu_rsp_if.sv
// ----------------------------------------------------------------------------
// lfu_rsp_if
// Result channel carrying hit or fault, frame, evicted page and fault total.
// ----------------------------------------------------------------------------
interface lfu_rsp_if
    import lfu_pkg::*;
();

    logic               valid;
    logic               ready;
    logic               hit;
    logic [SLOT_W-1:0]  frame_slot;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [TOTAL_W-1:0] fault_total;

    modport source (
        output valid, output hit, output frame_slot, output evicted_valid,
        output evicted_page, output fault_total, input ready
    );
    modport sink (
        input valid, input hit, input frame_slot, input evicted_valid,
        input evicted_page, input fault_total, output ready
    );

endinterface

FILE: rtl/lfu_page_replacement.sv
// ----------------------------------------------------------------------------
// lfu_page_replacement
// An accepted request is held in the input register; its result is then
// registered in the response register. One request per cycle unless the
// response side stalls. All frames are compared in parallel; the victim is
// the first empty frame, else from a small comparison tree over the counters.
// Reset empties every frame and clears the access and fault counters.
// ----------------------------------------------------------------------------
module lfu_page_replacement
    import lfu_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    lfu_req_if.sink       req,
    lfu_rsp_if.source     rsp
);

    localparam int STORE_BITS = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int IDX_W      = $clog2(FRAME_COUNT);
    localparam int LEAF_COUNT = 1 << IDX_W;
    localparam int NODE_COUNT = 2 * LEAF_COUNT - 1;
    localparam int KEY_W      = 1 + USE_W + STAMP_W;

    logic                  in_valid_reg;
    logic [STORE_BITS-1:0] in_page_reg;

    logic                  frame_valid_reg [FRAME_COUNT];
    logic [STORE_BITS-1:0] frame_page_reg  [FRAME_COUNT];
    logic [USE_W-1:0]      use_count_reg   [FRAME_COUNT];
    logic [STAMP_W-1:0]    load_stamp_reg  [FRAME_COUNT];
    logic [STAMP_W-1:0]    access_index_reg;
    logic [TOTAL_W-1:0]    fault_count_reg;

    logic                  rsp_valid_reg;
    logic                  rsp_hit_reg;
    logic [SLOT_W-1:0]     rsp_slot_reg;
    logic                  rsp_ev_valid_reg;
    logic [PAGE_W-1:0]     rsp_ev_page_reg;
    logic [TOTAL_W-1:0]    rsp_total_reg;

    logic                  advance;
    logic                  hit_any;
    logic [IDX_W-1:0]      hit_idx;
    logic                  empty_any;
    logic [IDX_W-1:0]      empty_idx;
    logic [IDX_W-1:0]      victim_idx;
    logic [IDX_W-1:0]      slot;
    logic                  ev_valid;
    logic [PAGE_W-1:0]     ev_page;
    logic [TOTAL_W-1:0]    fault_count_next;
    logic [STAMP_W-1:0]    access_index_next;
    logic [USE_W-1:0]      use_count_next;

    logic [KEY_W-1:0]      node_key [NODE_COUNT];
    logic [IDX_W-1:0]      node_idx [NODE_COUNT];

    assign advance   = in_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    always_comb
    begin
        hit_any   = 1'b0;
        hit_idx   = '0;
        empty_any = 1'b0;
        empty_idx = '0;
        for (int f = 0; f < FRAME_COUNT; f++)
        begin
            if (!hit_any && frame_valid_reg[f] && frame_page_reg[f] == in_page_reg)
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(f);
            end
            if (!empty_any && !frame_valid_reg[f])
            begin
                empty_any = 1'b1;
                empty_idx = IDX_W'(f);
            end
        end
    end

    // Lowest use count wins, then oldest stamp, then lowest index. Padding
    // leaves carry a set top key bit so they never win.
    always_comb
    begin
        for (int j = 0; j < LEAF_COUNT; j++)
        begin
            if (j < FRAME_COUNT)
            begin
                node_key[LEAF_COUNT - 1 + j] = {1'b0, use_count_reg[j], load_stamp_reg[j]};
                node_idx[LEAF_COUNT - 1 + j] = IDX_W'(j);
            end
            else
            begin
                node_key[LEAF_COUNT - 1 + j] = '1;
                node_idx[LEAF_COUNT - 1 + j] = '0;
            end
        end
        for (int n = LEAF_COUNT - 2; n >= 0; n--)
        begin
            if (node_key[2 * n + 2] < node_key[2 * n + 1])
            begin
                node_key[n] = node_key[2 * n + 2];
                node_idx[n] = node_idx[2 * n + 2];
            end
            else
            begin
                node_key[n] = node_key[2 * n + 1];
                node_idx[n] = node_idx[2 * n + 1];
            end
        end
    end

    always_comb
    begin
        victim_idx = empty_any ? empty_idx : node_idx[0];
        slot       = hit_any ? hit_idx : victim_idx;
        ev_valid   = !hit_any && !empty_any;
        ev_page    = ev_valid ? PAGE_W'(frame_page_reg[victim_idx]) : '0;

        if (!hit_any && fault_count_reg != '1)
            fault_count_next = fault_count_reg + TOTAL_W'(1);
        else
            fault_count_next = fault_count_reg;

        if (access_index_reg != '1)
            access_index_next = access_index_reg + STAMP_W'(1);
        else
            access_index_next = access_index_reg;

        if (use_count_reg[hit_idx] != '1)
            use_count_next = use_count_reg[hit_idx] + USE_W'(1);
        else
            use_count_next = use_count_reg[hit_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            access_index_reg <= '0;
            fault_count_reg  <= '0;
            for (int f = 0; f < FRAME_COUNT; f++)
            begin
                frame_valid_reg[f] <= 1'b0;
            end
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg    <= 1'b1;
                access_index_reg <= access_index_next;
                fault_count_reg  <= fault_count_next;
                if (!hit_any)
                begin
                    frame_valid_reg[slot] <= 1'b1;
                end
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_page_reg <= STORE_BITS'(req.page_number);
        end
        if (advance)
        begin
            rsp_hit_reg      <= hit_any;
            rsp_slot_reg     <= SLOT_W'(slot);
            rsp_ev_valid_reg <= ev_valid;
            rsp_ev_page_reg  <= ev_page;
            rsp_total_reg    <= fault_count_next;
            if (hit_any)
            begin
                use_count_reg[slot] <= use_count_next;
            end
            else
            begin
                frame_page_reg[slot] <= in_page_reg;
                use_count_reg[slot]  <= USE_W'(1);
                load_stamp_reg[slot] <= access_index_reg;
            end
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.hit           = rsp_hit_reg;
    assign rsp.frame_slot    = rsp_slot_reg;
    assign rsp.evicted_valid = rsp_ev_valid_reg;
    assign rsp.evicted_page  = rsp_ev_page_reg;
    assign rsp.fault_total   = rsp_total_reg;

endmodule
